// File: rtl/bpc_pkg.sv
// ============================================================================
// Barometric pressure compensation: shared package
// Field widths, internal datapath widths and configuration register indexes.
// ============================================================================
package bpc_pkg;

    // Widths of the port fields.
    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int PRES_W  = 32;
    localparam int CIDX_W  = 3;

    // Internal datapath widths, sized for the full range of every input.
    localparam int DT_W    = 25;   // temperature difference, signed
    localparam int PROD_W  = 42;   // calibration word times difference, signed
    localparam int Q_W     = 18;   // TEMP - 2000, signed
    localparam int SQ_W    = 35;   // squared temperature terms, unsigned
    localparam int CORR_W  = 39;   // second-order corrections, unsigned
    localparam int OFF_W   = 40;   // offset, signed
    localparam int SENS_W  = 39;   // sensitivity, signed
    localparam int SLO_W   = 20;   // low slice of the sensitivity in the wide multiply
    localparam int PP_W    = 44;   // partial products of the wide multiply
    localparam int X_W     = 64;   // raw pressure times sensitivity, signed
    localparam int Y_W     = 44;   // scaled product less offset, signed

    // Configuration register indexes.
    typedef enum logic [CIDX_W-1:0] {
        CFG_C1 = 3'd0,
        CFG_C2 = 3'd1,
        CFG_C3 = 3'd2,
        CFG_C4 = 3'd3,
        CFG_C5 = 3'd4,
        CFG_C6 = 3'd5
    } t_cfg_idx;

endpackage

// File: rtl/bpc_wide_mul.sv
// ============================================================================
// Barometric pressure compensation: wide multiplier
// Two-stage signed multiply of the raw pressure count by the sensitivity,
// split into two partial products that are registered and then recombined.
// ============================================================================
module bpc_wide_mul (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic        [bpc_pkg::RAW_W-1:0]      i_d1,
    input  logic signed [bpc_pkg::SENS_W-1:0]     i_sens,
    output logic                                  o_valid,
    output logic signed [bpc_pkg::X_W-1:0]        o_prod
);

    logic                                r_pp_valid;
    logic        [bpc_pkg::PP_W-1:0]     r_pp_lo;
    logic signed [bpc_pkg::PP_W-1:0]     r_pp_hi;
    logic                                r_x_valid;
    logic signed [bpc_pkg::X_W-1:0]      r_x;

    logic        [bpc_pkg::PP_W-1:0]     n_pp_lo;
    logic signed [bpc_pkg::PP_W-1:0]     n_pp_hi;
    logic signed [bpc_pkg::X_W-1:0]      n_x;

    // Partial products: unsigned low slice and signed high slice of the sensitivity.
    assign n_pp_lo = {{(bpc_pkg::PP_W-bpc_pkg::RAW_W){1'b0}}, i_d1}
                   * {{(bpc_pkg::PP_W-bpc_pkg::SLO_W){1'b0}}, i_sens[bpc_pkg::SLO_W-1:0]};
    assign n_pp_hi = $signed({1'b0, i_d1}) * $signed(i_sens[bpc_pkg::SENS_W-1:bpc_pkg::SLO_W]);

    // Recombine the partial products at their weights.
    assign n_x = ($signed({{(bpc_pkg::X_W-bpc_pkg::PP_W){r_pp_hi[bpc_pkg::PP_W-1]}}, r_pp_hi})
                  <<< bpc_pkg::SLO_W)
               + $signed({{(bpc_pkg::X_W-bpc_pkg::PP_W){1'b0}}, r_pp_lo});

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_valid <= 1'b0;
            r_x_valid  <= 1'b0;
        end else begin
            r_pp_valid <= i_valid;
            r_x_valid  <= r_pp_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pp_lo <= n_pp_lo;
        r_pp_hi <= n_pp_hi;
        r_x     <= n_x;
    end

    assign o_valid = r_x_valid;
    assign o_prod  = r_x;

endmodule

// File: rtl/baro_pressure_compensation.sv
// ============================================================================
// Barometric pressure compensation
// Second-order compensation of a raw pressure and temperature count pair,
// giving the pressure in units of 0.01 mbar.
// ============================================================================
// A new word may be started in every clock cycle: busy is never raised, and
// the pipeline has no stall path because results cannot be held off. The
// compensated pressure appears on o_pressure with o_valid high for one cycle,
// after the word has passed through the pipeline stages: difference, three
// products, scaling, squares, corrections, subtraction, the two-stage wide
// multiply, and two rounding stages. The calibration registers are written
// through the configuration channel, which is always ready, and must only be
// changed while no word is in flight.
module baro_pressure_compensation (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Command channel
    input  logic                                  start,
    output logic                                  busy,
    input  logic        [bpc_pkg::RAW_W-1:0]      i_raw_pressure,
    input  logic        [bpc_pkg::RAW_W-1:0]      i_raw_temperature,
    // Result channel
    output logic                                  o_valid,
    output logic signed [bpc_pkg::PRES_W-1:0]     o_pressure,
    // Configuration channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic        [bpc_pkg::CIDX_W-1:0]     i_cfg_index,
    input  logic        [bpc_pkg::CAL_W-1:0]      i_cfg_data
);

    // Calibration registers.
    logic [bpc_pkg::CAL_W-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    // Stage registers.
    logic                                r1_valid;
    logic        [bpc_pkg::RAW_W-1:0]    r1_d1;
    logic signed [bpc_pkg::DT_W-1:0]     r1_dt;

    logic                                r2_valid;
    logic        [bpc_pkg::RAW_W-1:0]    r2_d1;
    logic signed [bpc_pkg::PROD_W-1:0]   r2_m_off, r2_m_sens, r2_m_temp;

    logic                                r3_valid;
    logic        [bpc_pkg::RAW_W-1:0]    r3_d1;
    logic signed [bpc_pkg::OFF_W-1:0]    r3_off_base;
    logic signed [bpc_pkg::SENS_W-1:0]   r3_sens_base;
    logic signed [bpc_pkg::Q_W-1:0]      r3_q;

    logic                                r4_valid;
    logic        [bpc_pkg::RAW_W-1:0]    r4_d1;
    logic signed [bpc_pkg::OFF_W-1:0]    r4_off_base;
    logic signed [bpc_pkg::SENS_W-1:0]   r4_sens_base;
    logic        [bpc_pkg::SQ_W-1:0]     r4_sq1, r4_sq2;
    logic                                r4_low, r4_vlow;

    logic                                r5_valid;
    logic        [bpc_pkg::RAW_W-1:0]    r5_d1;
    logic signed [bpc_pkg::OFF_W-1:0]    r5_off_base;
    logic signed [bpc_pkg::SENS_W-1:0]   r5_sens_base;
    logic        [bpc_pkg::CORR_W-1:0]   r5_off2, r5_sens2;

    logic                                r6_valid;
    logic        [bpc_pkg::RAW_W-1:0]    r6_d1;
    logic signed [bpc_pkg::OFF_W-1:0]    r6_off;
    logic signed [bpc_pkg::SENS_W-1:0]   r6_sens;

    logic signed [bpc_pkg::OFF_W-1:0]    r7_off, r8_off;

    logic                                r9_valid;
    logic signed [bpc_pkg::Y_W-1:0]      r9_y;

    logic                                r_out_valid;
    logic signed [bpc_pkg::PRES_W-1:0]   r_pressure;

    // Next values.
    logic                                n_accept;
    logic signed [bpc_pkg::DT_W-1:0]     n1_dt;
    logic signed [bpc_pkg::PROD_W-1:0]   n2_m_off, n2_m_sens, n2_m_temp;
    logic signed [bpc_pkg::PROD_W-1:0]   n3_t_off, n3_t_sens, n3_t_temp;
    logic signed [bpc_pkg::OFF_W-1:0]    n3_off_base;
    logic signed [bpc_pkg::SENS_W-1:0]   n3_sens_base;
    logic signed [bpc_pkg::Q_W-1:0]      n3_q;
    logic signed [bpc_pkg::Q_W:0]        n4_qe;
    logic signed [2*bpc_pkg::Q_W-1:0]    n4_sq1_full;
    logic signed [2*bpc_pkg::Q_W+1:0]    n4_sq2_full;
    logic        [bpc_pkg::SQ_W+2:0]     n5_f5, n5_f7;
    logic        [bpc_pkg::SQ_W+3:0]     n5_f11;
    logic        [bpc_pkg::CORR_W-1:0]   n5_off2, n5_sens2;
    logic signed [bpc_pkg::OFF_W-1:0]    n6_off;
    logic signed [bpc_pkg::SENS_W:0]     n6_sens_w;
    logic                                mul_valid;
    logic signed [bpc_pkg::X_W-1:0]      mul_prod;
    logic signed [bpc_pkg::X_W-1:0]      n9_t;
    logic signed [bpc_pkg::Y_W-1:0]      n9_y;
    logic signed [bpc_pkg::Y_W-1:0]      n10_t;
    logic signed [bpc_pkg::PRES_W-1:0]   n10_pressure;

    // Handshakes: the pipeline never stalls.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign n_accept    = start && !busy;

    // Calibration register writes; indexes past the last register are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bpc_pkg::CFG_C1: r_c1 <= i_cfg_data;
                bpc_pkg::CFG_C2: r_c2 <= i_cfg_data;
                bpc_pkg::CFG_C3: r_c3 <= i_cfg_data;
                bpc_pkg::CFG_C4: r_c4 <= i_cfg_data;
                bpc_pkg::CFG_C5: r_c5 <= i_cfg_data;
                bpc_pkg::CFG_C6: r_c6 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Stage 1: temperature difference dT = D2 - C5 * 256.
    assign n1_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, r_c5, 8'h00});

    // Stage 2: the three products of dT with calibration words.
    assign n2_m_off  = $signed({1'b0, r_c4}) * r1_dt;
    assign n2_m_sens = $signed({1'b0, r_c3}) * r1_dt;
    assign n2_m_temp = $signed({1'b0, r_c6}) * r1_dt;

    // Stage 3: scale the products with truncation toward zero, add the base terms.
    assign n3_t_off  = r2_m_off  + (r2_m_off[bpc_pkg::PROD_W-1]  ? 42'sd127 : 42'sd0);
    assign n3_t_sens = r2_m_sens + (r2_m_sens[bpc_pkg::PROD_W-1] ? 42'sd255 : 42'sd0);
    assign n3_t_temp = r2_m_temp + (r2_m_temp[bpc_pkg::PROD_W-1] ? 42'sd8388607 : 42'sd0);

    assign n3_off_base  = $signed({8'h00, r_c2, 16'h0000})
                        + $signed({{5{n3_t_off[41]}}, n3_t_off[41:7]});
    assign n3_sens_base = $signed({8'h00, r_c1, 15'h0000})
                        + $signed({{5{n3_t_sens[41]}}, n3_t_sens[41:8]});
    // The scaled temperature product always fits in 18 bits.
    assign n3_q         = n3_t_temp[40:23];

    // Stage 4: squares of TEMP - 2000 and TEMP + 1500, and the range flags.
    assign n4_qe       = $signed({r3_q[bpc_pkg::Q_W-1], r3_q}) + 19'sd3500;
    assign n4_sq1_full = r3_q * r3_q;
    assign n4_sq2_full = n4_qe * n4_qe;

    // Stage 5: second-order corrections from the squares.
    assign n5_f5    = {1'b0, r4_sq1, 2'b00} + {3'b000, r4_sq1};
    assign n5_f7    = {r4_sq2, 3'b000} - {3'b000, r4_sq2};
    assign n5_f11   = {1'b0, r4_sq2, 3'b000} + {3'b000, r4_sq2, 1'b0} + {4'h0, r4_sq2};
    assign n5_off2  = (r4_low  ? {2'b00, n5_f5[37:1]} : '0)
                    + (r4_vlow ? {1'b0, n5_f7}        : '0);
    assign n5_sens2 = (r4_low  ? {3'b000, n5_f5[37:2]} : '0)
                    + (r4_vlow ? {1'b0, n5_f11[38:1]}  : '0);

    // Stage 6: apply the corrections to offset and sensitivity.
    assign n6_off    = r5_off_base - $signed({1'b0, r5_off2});
    assign n6_sens_w = $signed({r5_sens_base[bpc_pkg::SENS_W-1], r5_sens_base})
                     - $signed({1'b0, r5_sens2});

    // Stages 7 and 8: raw pressure times sensitivity.
    bpc_wide_mul u_wide_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r6_valid),
        .i_d1    (r6_d1),
        .i_sens  (r6_sens),
        .o_valid (mul_valid),
        .o_prod  (mul_prod)
    );

    // Stage 9: divide by 2^21 toward zero and subtract the offset.
    assign n9_t = mul_prod + (mul_prod[bpc_pkg::X_W-1] ? 64'sd2097151 : 64'sd0);
    assign n9_y = $signed({n9_t[63], n9_t[63:21]}) - $signed({{4{r8_off[39]}}, r8_off});

    // Stage 10: divide by 2^15 toward zero and sign-extend the quotient to 32 bits.
    assign n10_t        = r9_y + (r9_y[bpc_pkg::Y_W-1] ? 44'sd32767 : 44'sd0);
    assign n10_pressure = $signed({{3{n10_t[43]}}, n10_t[43:15]});

    // Valid bits travel with the words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r6_valid    <= 1'b0;
            r9_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r1_valid    <= n_accept;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid;
            r5_valid    <= r4_valid;
            r6_valid    <= r5_valid;
            r9_valid    <= mul_valid;
            r_out_valid <= r9_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r1_d1        <= i_raw_pressure;
        r1_dt        <= n1_dt;

        r2_d1        <= r1_d1;
        r2_m_off     <= n2_m_off;
        r2_m_sens    <= n2_m_sens;
        r2_m_temp    <= n2_m_temp;

        r3_d1        <= r2_d1;
        r3_off_base  <= n3_off_base;
        r3_sens_base <= n3_sens_base;
        r3_q         <= n3_q;

        r4_d1        <= r3_d1;
        r4_off_base  <= r3_off_base;
        r4_sens_base <= r3_sens_base;
        r4_sq1       <= n4_sq1_full[bpc_pkg::SQ_W-1:0];
        r4_sq2       <= n4_sq2_full[bpc_pkg::SQ_W-1:0];
        r4_low       <= r3_q[bpc_pkg::Q_W-1];
        r4_vlow      <= n4_qe[bpc_pkg::Q_W];

        r5_d1        <= r4_d1;
        r5_off_base  <= r4_off_base;
        r5_sens_base <= r4_sens_base;
        r5_off2      <= n5_off2;
        r5_sens2     <= n5_sens2;

        r6_d1        <= r5_d1;
        r6_off       <= n6_off;
        r6_sens      <= n6_sens_w[bpc_pkg::SENS_W-1:0];

        r7_off       <= r6_off;
        r8_off       <= r7_off;

        r9_y         <= n9_y;
        r_pressure   <= n10_pressure;
    end

    assign o_valid    = r_out_valid;
    assign o_pressure = r_pressure;

endmodule
